// ----- rtl/tmhq_pkg.sv -----
// tmhq_pkg: shared types, constants and command codes for the timer heap queue
// depends on nothing
package tmhq_pkg;

    localparam int HEAP_DEPTH_DEF = 64;
    localparam int TIMER_IDS_DEF  = 256;
    localparam int TIME_BITS_DEF  = 48;
    localparam logic [15:0] EMPTY_WAIT_RESET = 16'd1000;

    localparam logic [2:0] CMD_ADD    = 3'd0;
    localparam logic [2:0] CMD_CANCEL = 3'd1;
    localparam logic [2:0] CMD_CHECK  = 3'd2;
    localparam logic [2:0] CMD_QUERY  = 3'd3;
    localparam logic [2:0] CMD_STOP   = 3'd4;

    localparam logic [1:0] KIND_NOTIFY = 2'd0;
    localparam logic [1:0] KIND_REMAIN = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    typedef struct packed {
        logic [2:0]               cmd;
        logic [7:0]               timer_id;
        logic [TIME_BITS_DEF-1:0] deadline;
        logic [TIME_BITS_DEF-1:0] now;
    } t_in_item;

    typedef struct packed {
        logic [1:0]               kind;
        logic [7:0]               expired_id;
        logic [TIME_BITS_DEF-1:0] remaining;
        logic                     last;
    } t_out_item;

endpackage

// ----- rtl/tmhq_ram.sv -----
// tmhq_ram: generic single-port ram with registered read
// depends on nothing
module tmhq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write or registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ----- rtl/timer_min_heap_queue_core.sv -----
// timer_min_heap_queue_core: timer heap queue top, uses tmhq_pkg and tmhq_ram
// steps: cancel sets the id's mark; add clears it and sifts the entry up a level at a time;
// a reject or query answer is registered at the output; check and query read the top and
// its mark, a pop sifts the last entry down from the top; stop all marks and drops every entry
// throughput: one transaction at a time, input stalled until the command finishes
// reset: synchronous active low, then a pass over all TIMER_IDS ids clears the cancel marks
module timer_min_heap_queue_core #(
    parameter int HEAP_DEPTH = tmhq_pkg::HEAP_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  tmhq_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output tmhq_pkg::t_out_item o_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [15:0]         i_cfg_data
);
    localparam int TIMER_IDS = tmhq_pkg::TIMER_IDS_DEF;
    localparam int TIME_BITS = tmhq_pkg::TIME_BITS_DEF;
    localparam int AW  = $clog2(HEAP_DEPTH);
    localparam int CW  = $clog2(HEAP_DEPTH + 1);
    localparam int IW  = $clog2(TIMER_IDS);
    localparam int EW  = TIME_BITS + IW;
    localparam logic [CW-1:0] FULL = CW'(HEAP_DEPTH);

    typedef enum logic [15:0] {
        S_CLR   = 16'h0001, S_IDLE  = 16'h0002, S_OUT   = 16'h0004,
        S_UPRD  = 16'h0008, S_UPCMP = 16'h0010, S_TOPRD = 16'h0020,
        S_TOPWT = 16'h0040, S_TOPCK = 16'h0080, S_POP   = 16'h0100,
        S_POPWT = 16'h0200, S_DNL   = 16'h0400, S_DNR   = 16'h0800,
        S_DNCMP = 16'h1000, S_DNWR  = 16'h2000, S_STRD  = 16'h4000,
        S_STMK  = 16'h8000
    } t_state;

    t_state              r_state;
    t_state              r_ret;
    tmhq_pkg::t_in_item  r_in;
    logic [CW-1:0]       r_cnt;
    logic [AW-1:0]       r_pos;
    logic [AW-1:0]       r_child;
    logic [EW-1:0]       r_cur, r_a;
    logic [CW-1:0]       r_idx;
    logic [IW-1:0]       r_clr;
    logic [15:0]         r_wait;
    logic                r_ovalid;
    tmhq_pkg::t_out_item r_out;
    tmhq_pkg::t_out_item r_res;
    logic                r_pend;
    logic [7:0]          r_pend_id;

    // heap ram port
    logic          h_we;
    logic [AW-1:0] h_addr;
    logic [EW-1:0] h_wdata, h_rdata;
    // cancel mark ram port
    logic          m_we;
    logic [IW-1:0] m_addr;
    logic          m_wdata, m_rdata;

    tmhq_ram #(.WIDTH(EW), .DEPTH(HEAP_DEPTH)) u_heap (
        .i_clk(i_clk), .i_we(h_we), .i_addr(h_addr), .i_wdata(h_wdata), .o_rdata(h_rdata)
    );
    tmhq_ram #(.WIDTH(1), .DEPTH(TIMER_IDS)) u_mark (
        .i_clk(i_clk), .i_we(m_we), .i_addr(m_addr), .i_wdata(m_wdata), .o_rdata(m_rdata)
    );

    function automatic logic [TIME_BITS-1:0] f_t(input logic [EW-1:0] e);
        return e[EW-1:IW];
    endfunction

    function automatic tmhq_pkg::t_out_item f_res(input logic [1:0] k,
                                                  input logic [7:0] d,
                                                  input logic [TIME_BITS-1:0] r,
                                                  input logic l);
        tmhq_pkg::t_out_item o;
        o.kind       = k;
        o.expired_id = d;
        o.remaining  = r;
        o.last       = l;
        return o;
    endfunction

    logic [TIME_BITS-1:0] w_now;
    assign w_now = r_in.now[TIME_BITS-1:0];

    // parent and child positions of the hole
    logic [AW-1:0] w_par, w_l, w_r;
    logic [AW+1:0] w_l2, w_r2;
    logic          w_has_l, w_has_r;
    assign w_par   = AW'((r_pos - AW'(1)) >> 1);
    assign w_l2    = {1'b0, r_pos, 1'b1};
    assign w_r2    = w_l2 + (AW + 2)'(1);
    assign w_l     = w_l2[AW-1:0];
    assign w_r     = w_r2[AW-1:0];
    assign w_has_l = (w_l2 < (AW + 2)'(r_cnt));
    assign w_has_r = (w_r2 < (AW + 2)'(r_cnt));

    // single shared comparator
    logic [TIME_BITS-1:0] w_ca, w_cb;
    logic                 w_lt;
    assign w_lt = w_ca < w_cb;

    logic w_load;
    assign o_cfg_ready = (r_state == S_IDLE) && !i_valid;
    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_ovalid;
    assign o_data      = r_out;

    logic [AW-1:0] w_cnt_m1;
    assign w_cnt_m1 = AW'(r_cnt - CW'(1));

    // ram ports, comparator operands and output load
    always_comb begin
        h_we = 1'b0; h_addr = r_pos; h_wdata = r_cur;
        m_we = 1'b0; m_addr = i_data.timer_id[IW-1:0]; m_wdata = 1'b0;
        w_ca = f_t(r_cur); w_cb = f_t(h_rdata);
        w_load = 1'b0;
        case (r_state)
            S_CLR: begin
                m_we = 1'b1; m_addr = r_clr;
            end
            S_IDLE: begin
                if (i_valid) begin
                    if (i_data.cmd == tmhq_pkg::CMD_CANCEL) begin
                        m_we = 1'b1; m_wdata = 1'b1;
                    end else if (i_data.cmd == tmhq_pkg::CMD_ADD && r_cnt < FULL) begin
                        m_we = 1'b1;
                    end
                end
            end
            S_OUT: w_load = !r_ovalid || !i_stall;
            S_UPRD: begin
                if (r_pos == '0) begin
                    h_we = 1'b1;
                end else begin
                    h_addr = w_par;
                end
            end
            S_UPCMP: begin
                // new entry against its parent
                h_we = 1'b1;
                if (w_lt) h_wdata = h_rdata;
            end
            S_TOPRD: h_addr = '0;
            S_TOPWT: m_addr = h_rdata[IW-1:0];
            S_TOPCK: begin
                w_ca = w_now; w_cb = f_t(r_cur);
            end
            S_POP: h_addr = w_cnt_m1;
            S_DNL: begin
                if (w_has_l) begin
                    h_addr = w_l;
                end else begin
                    h_we = 1'b1;
                end
            end
            S_DNR: begin
                if (w_has_r) h_addr = w_r;
            end
            S_DNCMP: begin
                w_ca = f_t(h_rdata); w_cb = f_t(r_a);
            end
            S_DNWR: begin
                w_ca = f_t(r_a); w_cb = f_t(r_cur);
                h_we = 1'b1;
                if (w_lt) h_wdata = r_a;
            end
            S_STRD: h_addr = AW'(r_idx);
            S_STMK: begin
                m_we = 1'b1; m_addr = h_rdata[IW-1:0]; m_wdata = 1'b1;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
            r_out    <= r_res;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_cnt   <= '0;
            r_pos   <= '0;
            r_wait  <= tmhq_pkg::EMPTY_WAIT_RESET;
            r_pend  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) r_wait <= i_cfg_data;
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + IW'(1);
                    if (r_clr == IW'(TIMER_IDS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_in   <= i_data;
                        r_pend <= 1'b0;
                        case (i_data.cmd)
                            tmhq_pkg::CMD_ADD: begin
                                if (r_cnt >= FULL) begin
                                    r_res   <= f_res(tmhq_pkg::KIND_REJECT,
                                                     i_data.timer_id, '0, 1'b1);
                                    r_ret   <= S_IDLE;
                                    r_state <= S_OUT;
                                end else begin
                                    r_pos   <= AW'(r_cnt);
                                    r_cur   <= {i_data.deadline[TIME_BITS-1:0],
                                                i_data.timer_id[IW-1:0]};
                                    r_cnt   <= r_cnt + CW'(1);
                                    r_state <= S_UPRD;
                                end
                            end
                            tmhq_pkg::CMD_CHECK, tmhq_pkg::CMD_QUERY: r_state <= S_TOPRD;
                            tmhq_pkg::CMD_STOP: begin
                                r_idx   <= '0;
                                r_state <= S_STRD;
                            end
                            default: ;
                        endcase
                    end
                end
                S_OUT: begin
                    if (w_load) r_state <= r_ret;
                end
                S_UPRD: begin
                    if (r_pos == '0) r_state <= S_IDLE;
                    else r_state <= S_UPCMP;
                end
                S_UPCMP: begin
                    if (w_lt) begin
                        r_pos   <= w_par;
                        r_state <= S_UPRD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_TOPRD: begin
                    if (r_cnt == '0) begin
                        if (r_in.cmd == tmhq_pkg::CMD_QUERY) begin
                            r_res   <= f_res(tmhq_pkg::KIND_REMAIN, 8'd0,
                                             TIME_BITS'(r_wait), 1'b1);
                            r_ret   <= S_IDLE;
                            r_state <= S_OUT;
                        end else if (r_pend) begin
                            r_res   <= f_res(tmhq_pkg::KIND_NOTIFY, r_pend_id, '0, 1'b1);
                            r_pend  <= 1'b0;
                            r_ret   <= S_IDLE;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_state <= S_TOPWT;
                    end
                end
                S_TOPWT: begin
                    r_cur   <= h_rdata;
                    r_state <= S_TOPCK;
                end
                S_TOPCK: begin
                    // m_rdata holds the cancel mark of the top id
                    if (m_rdata) begin
                        r_state <= S_POP;
                    end else if (r_in.cmd == tmhq_pkg::CMD_QUERY) begin
                        r_res   <= f_res(tmhq_pkg::KIND_REMAIN, 8'd0,
                                         w_lt ? f_t(r_cur) - w_now : '0, 1'b1);
                        r_ret   <= S_IDLE;
                        r_state <= S_OUT;
                    end else if (!w_lt) begin
                        // due: the held notify is not the last one
                        r_pend    <= 1'b1;
                        r_pend_id <= 8'(r_cur[IW-1:0]);
                        if (r_pend) begin
                            r_res   <= f_res(tmhq_pkg::KIND_NOTIFY, r_pend_id, '0, 1'b0);
                            r_ret   <= S_POP;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_POP;
                        end
                    end else if (r_pend) begin
                        r_res   <= f_res(tmhq_pkg::KIND_NOTIFY, r_pend_id, '0, 1'b1);
                        r_pend  <= 1'b0;
                        r_ret   <= S_IDLE;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_POP: begin
                    r_cnt   <= r_cnt - CW'(1);
                    r_state <= S_POPWT;
                end
                S_POPWT: begin
                    r_cur   <= h_rdata;
                    r_pos   <= '0;
                    r_state <= (r_cnt == '0) ? S_TOPRD : S_DNL;
                end
                S_DNL: begin
                    if (w_has_l) r_state <= S_DNR;
                    else r_state <= S_TOPRD;
                end
                S_DNR: begin
                    r_a     <= h_rdata;
                    r_child <= w_l;
                    r_state <= w_has_r ? S_DNCMP : S_DNWR;
                end
                S_DNCMP: begin
                    // right child wins only when strictly smaller
                    if (w_lt) begin
                        r_a     <= h_rdata;
                        r_child <= w_r;
                    end
                    r_state <= S_DNWR;
                end
                S_DNWR: begin
                    if (w_lt) begin
                        r_pos   <= r_child;
                        r_state <= S_DNL;
                    end else begin
                        r_state <= S_TOPRD;
                    end
                end
                S_STRD: begin
                    if (r_idx == r_cnt) begin
                        r_cnt   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_STMK;
                    end
                end
                S_STMK: begin
                    r_idx   <= r_idx + CW'(1);
                    r_state <= S_STRD;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // heap count never exceeds depth
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= FULL)
        else $error("heap count overflow");
    // state register stays one-hot
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_state))
        else $error("state not one-hot");
    // config accepted only when idle
    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> (r_state == S_IDLE)) else $error("config while busy");
    // a stalled result holds still
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data)))
        else $error("stalled result changed");
endmodule

// ----- verif/timer_min_heap_queue_core_tb.sv -----
// timer_min_heap_queue_core_tb: self-checking testbench for the timer heap queue core
// depends on tmhq_pkg and timer_min_heap_queue_core; predicts every result with a
// local heap model and checks it field by field against the block's output
`timescale 1ns / 100ps

module timer_min_heap_queue_core_tb;

    localparam int DEPTH    = tmhq_pkg::HEAP_DEPTH_DEF;
    localparam int IDS      = tmhq_pkg::TIMER_IDS_DEF;
    localparam int SETTLE   = 400;
    localparam logic [47:0] TMAX = 48'hFFFF_FFFF_FFFF;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    tmhq_pkg::t_in_item  i_data = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    tmhq_pkg::t_out_item o_data;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [15:0]         i_cfg_data = '0;

    // pending commands and expected results
    tmhq_pkg::t_in_item  cmd_pending[$];
    tmhq_pkg::t_out_item results_due[$];

    // local heap state
    logic [47:0] heap_tick[DEPTH];
    logic [7:0]  heap_tid[DEPTH];
    int          heap_fill;
    bit          cancelled[IDS];
    logic [15:0] empty_answer;

    int   errors = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    bit   recv_busy = 1'b0;
    bit   took = 1'b0;
    logic [47:0] clock_now = '0;

    timer_min_heap_queue_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // heap model
    function automatic void heap_swap(int a, int b);
        logic [47:0] t;
        logic [7:0]  d;
        t = heap_tick[a]; heap_tick[a] = heap_tick[b]; heap_tick[b] = t;
        d = heap_tid[a];  heap_tid[a]  = heap_tid[b];  heap_tid[b]  = d;
    endfunction

    function automatic void heap_insert(logic [47:0] t, logic [7:0] d);
        int pos;
        int parent;
        pos = heap_fill;
        heap_tick[pos] = t;
        heap_tid[pos] = d;
        heap_fill++;
        while (pos > 0) begin
            parent = (pos - 1) / 2;
            if (heap_tick[pos] < heap_tick[parent]) begin
                heap_swap(pos, parent);
                pos = parent;
            end else begin
                break;
            end
        end
    endfunction

    function automatic void heap_remove_top();
        int pos;
        int l;
        int c;
        pos = 0;
        if (heap_fill == 0) return;
        heap_fill--;
        heap_tick[0] = heap_tick[heap_fill];
        heap_tid[0] = heap_tid[heap_fill];
        forever begin
            l = 2 * pos + 1;
            if (l >= heap_fill) break;
            c = l;
            if (l + 1 < heap_fill && heap_tick[l + 1] < heap_tick[l]) c = l + 1;
            if (heap_tick[c] < heap_tick[pos]) begin
                heap_swap(c, pos);
                pos = c;
            end else begin
                break;
            end
        end
    endfunction

    function automatic tmhq_pkg::t_out_item make_result(logic [1:0] k, logic [7:0] d,
                                                        logic [47:0] r);
        tmhq_pkg::t_out_item o;
        o.kind = k;
        o.expired_id = d;
        o.remaining = r;
        o.last = 1'b0;
        return o;
    endfunction

    // append one command to the pending queue
    function automatic void queue_cmd(tmhq_pkg::t_in_item it);
        cmd_pending = {cmd_pending, it};
    endfunction

    // expected results of one accepted command
    function automatic void predict_timer_results(tmhq_pkg::t_in_item it);
        tmhq_pkg::t_out_item outs[$];
        logic [7:0] top;
        case (it.cmd)
            tmhq_pkg::CMD_ADD: begin
                if (heap_fill >= DEPTH) begin
                    outs = {outs, make_result(tmhq_pkg::KIND_REJECT, it.timer_id, '0)};
                end else begin
                    cancelled[it.timer_id] = 1'b0;
                    heap_insert(it.deadline, it.timer_id);
                end
            end
            tmhq_pkg::CMD_CANCEL: cancelled[it.timer_id] = 1'b1;
            tmhq_pkg::CMD_CHECK: begin
                while (heap_fill > 0) begin
                    top = heap_tid[0];
                    if (cancelled[top]) begin
                        heap_remove_top();
                    end else if (it.now >= heap_tick[0]) begin
                        heap_remove_top();
                        outs = {outs, make_result(tmhq_pkg::KIND_NOTIFY, top, '0)};
                    end else begin
                        break;
                    end
                end
            end
            tmhq_pkg::CMD_QUERY: begin
                while (heap_fill > 0 && cancelled[heap_tid[0]]) heap_remove_top();
                if (heap_fill == 0)
                    outs = {outs, make_result(tmhq_pkg::KIND_REMAIN, '0,
                                              {32'd0, empty_answer})};
                else if (heap_tick[0] > it.now)
                    outs = {outs, make_result(tmhq_pkg::KIND_REMAIN, '0,
                                              heap_tick[0] - it.now)};
                else
                    outs = {outs, make_result(tmhq_pkg::KIND_REMAIN, '0, '0)};
            end
            tmhq_pkg::CMD_STOP: begin
                for (int i = 0; i < heap_fill; i++) cancelled[heap_tid[i]] = 1'b1;
                heap_fill = 0;
            end
            default: ;
        endcase
        if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
        foreach (outs[i]) results_due = {results_due, outs[i]};
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // driver: presents commands at the falling edge, holds them while stalled
    always @(negedge i_clk) begin
        if (!i_valid || took) begin
            if (i_rst_n && cmd_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_data <= cmd_pending.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stall, held high during a long hold-off
    always @(negedge i_clk) begin
        if (recv_busy) begin
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // long receiver hold-off, counted in cycles
    task automatic hold_receiver(int cycles);
        recv_busy = 1'b1;
        repeat (cycles) @(negedge i_clk);
        recv_busy = 1'b0;
    endtask

    // monitor: input transactions feed the model, output transactions are checked
    always @(posedge i_clk) begin
        tmhq_pkg::t_out_item want;
        took <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) begin
            predict_timer_results(i_data);
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (results_due.size() == 0) begin
                report_mismatch("unexpected transaction", 64'(o_data), '0);
            end else begin
                want = results_due.pop_front();
                if (o_data.kind != want.kind)
                    report_mismatch("kind", 64'(o_data.kind), 64'(want.kind));
                if (o_data.expired_id != want.expired_id)
                    report_mismatch("expired_id", 64'(o_data.expired_id),
                                    64'(want.expired_id));
                if (o_data.remaining != want.remaining)
                    report_mismatch("remaining", 64'(o_data.remaining),
                                    64'(want.remaining));
                if (o_data.last != want.last)
                    report_mismatch("last", 64'(o_data.last), 64'(want.last));
            end
        end
    end

    initial begin
        #8ms;
        $display("== FAIL ==");
        $finish;
    end

    function automatic tmhq_pkg::t_in_item cmd_item(logic [2:0] c, logic [7:0] d,
                                                    logic [47:0] t, logic [47:0] n);
        tmhq_pkg::t_in_item it;
        it.cmd = c;
        it.timer_id = d;
        it.deadline = t;
        it.now = n;
        return it;
    endfunction

    function automatic logic [47:0] wide_rand();
        return 48'({$urandom, $urandom});
    endfunction

    // random command, mostly a coherent timeline with a few wild values
    function automatic tmhq_pkg::t_in_item random_cmd();
        int sel;
        logic [7:0]  d;
        logic [47:0] t;
        sel = $urandom_range(99);
        d = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(15));
        t = ($urandom_range(15) == 0) ? wide_rand() : clock_now + 48'($urandom_range(300));
        if (sel < 40) return cmd_item(tmhq_pkg::CMD_ADD, d, t, wide_rand());
        if (sel < 55) return cmd_item(tmhq_pkg::CMD_CANCEL, d, wide_rand(), wide_rand());
        if (sel < 75) begin
            clock_now = clock_now + 48'($urandom_range(120));
            return cmd_item(tmhq_pkg::CMD_CHECK, 8'($urandom), wide_rand(),
                            ($urandom_range(19) == 0) ? wide_rand() : clock_now);
        end
        if (sel < 93)
            return cmd_item(tmhq_pkg::CMD_QUERY, 8'($urandom), wide_rand(),
                            ($urandom_range(19) == 0) ? wide_rand() : clock_now);
        if (sel < 97)
            return cmd_item(tmhq_pkg::CMD_STOP, 8'($urandom), wide_rand(), wide_rand());
        return cmd_item(3'($urandom_range(5, 7)), 8'($urandom), wide_rand(), wide_rand());
    endfunction

    // wait until every command is taken and every result has arrived
    task automatic drain();
        while (cmd_pending.size() > 0 || i_valid || results_due.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_empty_wait(logic [15:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        empty_answer = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_burst(int n);
        repeat (n) queue_cmd(random_cmd());
        drain();
    endtask

    initial begin
        heap_fill = 0;
        empty_answer = tmhq_pkg::EMPTY_WAIT_RESET;
        foreach (cancelled[i]) cancelled[i] = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, ties, cancel and revive, stop all, unused codes
        send_idle_pct = 29;
        recv_idle_pct = 87;
        queue_cmd(cmd_item(tmhq_pkg::CMD_QUERY, 8'd0, '0, 48'd5));
        queue_cmd(cmd_item(tmhq_pkg::CMD_ADD, 8'd0, '0, TMAX));
        queue_cmd(cmd_item(tmhq_pkg::CMD_ADD, 8'd255, TMAX, '0));
        queue_cmd(cmd_item(tmhq_pkg::CMD_ADD, 8'd7, 48'd100, '0));
        queue_cmd(cmd_item(tmhq_pkg::CMD_ADD, 8'd8, 48'd100, '0));
        queue_cmd(cmd_item(tmhq_pkg::CMD_ADD, 8'd9, 48'd100, '0));
        queue_cmd(cmd_item(tmhq_pkg::CMD_CANCEL, 8'd8, '0, '0));
        queue_cmd(cmd_item(tmhq_pkg::CMD_QUERY, 8'd0, '0, 48'd50));
        queue_cmd(cmd_item(tmhq_pkg::CMD_CHECK, 8'd0, '0, 48'd99));
        queue_cmd(cmd_item(tmhq_pkg::CMD_CHECK, 8'd0, '0, 48'd100));
        queue_cmd(cmd_item(tmhq_pkg::CMD_QUERY, 8'd0, '0, TMAX));
        queue_cmd(cmd_item(tmhq_pkg::CMD_CANCEL, 8'd255, TMAX, TMAX));
        queue_cmd(cmd_item(tmhq_pkg::CMD_QUERY, 8'd0, '0, '0));
        queue_cmd(cmd_item(tmhq_pkg::CMD_ADD, 8'd3, 48'd5, '0));
        queue_cmd(cmd_item(tmhq_pkg::CMD_CANCEL, 8'd3, '0, '0));
        queue_cmd(cmd_item(tmhq_pkg::CMD_ADD, 8'd3, 48'd9, '0));
        queue_cmd(cmd_item(tmhq_pkg::CMD_CHECK, 8'd0, '0, 48'd10));
        queue_cmd(cmd_item(tmhq_pkg::CMD_ADD, 8'd1, 48'd20, '0));
        queue_cmd(cmd_item(tmhq_pkg::CMD_ADD, 8'd2, TMAX, '0));
        queue_cmd(cmd_item(tmhq_pkg::CMD_STOP, 8'hFF, TMAX, TMAX));
        queue_cmd(cmd_item(tmhq_pkg::CMD_QUERY, 8'hFF, TMAX, TMAX));
        queue_cmd(cmd_item(tmhq_pkg::CMD_ADD, 8'd1, 48'd30, '0));
        queue_cmd(cmd_item(tmhq_pkg::CMD_CHECK, 8'd0, '0, TMAX));
        queue_cmd(cmd_item(3'd5, 8'hFF, TMAX, TMAX));
        queue_cmd(cmd_item(3'd7, 8'h00, '0, '0));
        drain();

        // random, register at its low extreme, then at its high extreme with the opposite idling
        write_empty_wait(16'd0);
        random_burst(20);
        send_idle_pct = 87;
        recv_idle_pct = 29;
        write_empty_wait(16'hFFFF);
        queue_cmd(cmd_item(tmhq_pkg::CMD_QUERY, 8'd0, '0, TMAX));
        random_burst(20);

        // pressure, no idling: receiver holds off while the heap overfills
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_empty_wait(16'($urandom));
        queue_cmd(cmd_item(tmhq_pkg::CMD_STOP, 8'd0, '0, '0));
        fork
            hold_receiver(1500);
        join_none
        for (int i = 0; i < DEPTH + 2; i++)
            queue_cmd(cmd_item(tmhq_pkg::CMD_ADD, 8'(i),
                               clock_now + 48'($urandom_range(40)), '0));
        queue_cmd(cmd_item(tmhq_pkg::CMD_CHECK, 8'd0, '0, clock_now + 48'd40));
        queue_cmd(cmd_item(tmhq_pkg::CMD_QUERY, 8'd0, '0, clock_now));
        drain();

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/tmhq_pkg.sv
rtl/tmhq_ram.sv
rtl/timer_min_heap_queue_core.sv
verif/timer_min_heap_queue_core_tb.sv
